// File: sv/bre_pkg.sv
package bre_pkg;

  localparam int COORD_W = 6;
  localparam int ROW_W   = 7;
  localparam int ADDR_W  = 12;
  localparam int COLOR_W = 24;
  localparam int ERR_W   = 9;
  localparam int INC_W   = 7;

  localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 7'd64;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SHALLOW,
    MODE_STEEP,
    MODE_AXIS
  } mode_t;

  // classified line request, as handed from the front end to the walker
  typedef struct packed {
    mode_t                     mode;
    logic                      major_y;
    logic                      minor_dec;
    coord_t                    x;
    coord_t                    y;
    coord_t                    walk_end;
    logic signed [ERR_W-1:0]   err;
    logic        [INC_W-1:0]   inc_a;
    logic signed [ERR_W-1:0]   inc_b;
    logic        [COLOR_W-1:0] color;
  } cmd_t;

endpackage

// File: sv/bre_front.sv
module bre_front (
  input  bre_pkg::coord_t                  start_x,
  input  bre_pkg::coord_t                  start_y,
  input  bre_pkg::coord_t                  end_x,
  input  bre_pkg::coord_t                  end_y,
  input  logic [bre_pkg::COLOR_W-1:0]      line_color,
  output bre_pkg::cmd_t                    cmd
);

  logic            dx_zero;
  logic            dy_zero;
  logic            x_up;
  logic            y_up;
  logic            shallow;
  bre_pkg::coord_t adx;
  bre_pkg::coord_t ady;
  bre_pkg::coord_t maj;
  bre_pkg::coord_t mnr;

  always_comb begin
    dx_zero = (start_x == end_x);
    dy_zero = (start_y == end_y);
    x_up    = (end_x >= start_x);
    y_up    = (end_y >= start_y);
    adx     = x_up ? (end_x - start_x) : (start_x - end_x);
    ady     = y_up ? (end_y - start_y) : (start_y - end_y);
    shallow = (ady <= adx);
    maj     = shallow ? adx : ady;
    mnr     = shallow ? ady : adx;
  end

  always_comb begin
    cmd       = '0;
    cmd.color = line_color;
    if (dx_zero || dy_zero) begin
      // axis aligned and single point lines walk up from the lower end
      cmd.mode = bre_pkg::MODE_AXIS;
      if (dx_zero) begin
        cmd.major_y  = 1'b1;
        cmd.x        = start_x;
        cmd.y        = y_up ? start_y : end_y;
        cmd.walk_end = y_up ? end_y : start_y;
      end else begin
        cmd.major_y  = 1'b0;
        cmd.y        = start_y;
        cmd.x        = x_up ? start_x : end_x;
        cmd.walk_end = x_up ? end_x : start_x;
      end
    end else begin
      cmd.minor_dec = (x_up != y_up);
      cmd.err       = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});
      cmd.inc_a     = {mnr, 1'b0};
      cmd.inc_b     = $signed({2'b00, mnr, 1'b0}) - $signed({2'b00, maj, 1'b0});
      if (shallow) begin
        cmd.mode     = bre_pkg::MODE_SHALLOW;
        cmd.major_y  = 1'b0;
        cmd.x        = x_up ? start_x : end_x;
        cmd.y        = x_up ? start_y : end_y;
        cmd.walk_end = x_up ? end_x : start_x;
      end else begin
        cmd.mode     = bre_pkg::MODE_STEEP;
        cmd.major_y  = 1'b1;
        cmd.x        = y_up ? start_x : end_x;
        cmd.y        = y_up ? start_y : end_y;
        cmd.walk_end = y_up ? end_y : start_y;
      end
    end
  end

endmodule

// File: sv/bre_cmd_queue.sv
module bre_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  bre_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_valid,
  output bre_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bre_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: sv/bre_walker.sv
module bre_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bre_pkg::ROW_W-1:0]     row_width,
  input  logic                          cmd_valid,
  input  bre_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic                          pop,
  output logic                          empty,
  output bre_pkg::coord_t               pixel_x,
  output bre_pkg::coord_t               pixel_y,
  output logic [bre_pkg::ADDR_W-1:0]    pixel_address,
  output logic [bre_pkg::COLOR_W-1:0]   pixel_color,
  output logic                          last_pixel
);

  bre_pkg::mode_t                       mode_r, mode_nxt;
  logic                                 major_y_r, major_y_nxt;
  logic                                 minor_dec_r, minor_dec_nxt;
  bre_pkg::coord_t                      x_r, x_nxt;
  bre_pkg::coord_t                      y_r, y_nxt;
  bre_pkg::coord_t                      end_r, end_nxt;
  logic signed [bre_pkg::ERR_W-1:0]     err_r, err_nxt;
  logic        [bre_pkg::INC_W-1:0]     inc_a_r, inc_a_nxt;
  logic signed [bre_pkg::ERR_W-1:0]     inc_b_r, inc_b_nxt;
  logic        [bre_pkg::COLOR_W-1:0]   color_r, color_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  bre_pkg::coord_t                      out_x_r, out_x_nxt;
  bre_pkg::coord_t                      out_y_r, out_y_nxt;
  logic [bre_pkg::ADDR_W-1:0]           out_addr_r, out_addr_nxt;
  logic [bre_pkg::COLOR_W-1:0]          out_color_r, out_color_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic                                 busy;
  logic                                 emit;
  logic                                 at_end;
  logic                                 load;
  logic                                 minor_step;
  bre_pkg::coord_t                      minor_next;
  logic [bre_pkg::ROW_W+bre_pkg::COORD_W-1:0] row_base;
  logic [bre_pkg::ADDR_W-1:0]           addr;

  always_comb begin
    busy    = (mode_r != bre_pkg::MODE_IDLE);
    emit    = busy && (!out_valid_r || pop);
    at_end  = ((major_y_r ? y_r : x_r) == end_r);
    load    = cmd_valid && (!busy || (emit && at_end));
    cmd_pop = load;
  end

  // shallow lines step the minor axis on err >= 0, steep ones only on err > 0
  always_comb begin
    case (mode_r)
      bre_pkg::MODE_SHALLOW: minor_step = !err_r[bre_pkg::ERR_W-1];
      bre_pkg::MODE_STEEP:   minor_step = !err_r[bre_pkg::ERR_W-1] && (err_r != '0);
      default:               minor_step = 1'b0;
    endcase
  end

  always_comb begin
    minor_next = major_y_r ? x_r : y_r;
    if (minor_step) begin
      minor_next = minor_dec_r ? minor_next - 1'b1 : minor_next + 1'b1;
    end
    row_base = row_width * y_r;
    addr     = bre_pkg::ADDR_W'(row_base) + bre_pkg::ADDR_W'(x_r);
  end

  // next state of the walk
  always_comb begin
    mode_nxt      = mode_r;
    major_y_nxt   = major_y_r;
    minor_dec_nxt = minor_dec_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    end_nxt       = end_r;
    err_nxt       = err_r;
    inc_a_nxt     = inc_a_r;
    inc_b_nxt     = inc_b_r;
    color_nxt     = color_r;
    if (emit) begin
      if (at_end) begin
        mode_nxt = bre_pkg::MODE_IDLE;
      end else begin
        if (major_y_r) begin
          y_nxt = y_r + 1'b1;
          x_nxt = minor_next;
        end else begin
          x_nxt = x_r + 1'b1;
          y_nxt = minor_next;
        end
        if (minor_step) begin
          err_nxt = err_r + inc_b_r;
        end else if (mode_r != bre_pkg::MODE_AXIS) begin
          err_nxt = err_r + $signed({2'b00, inc_a_r});
        end
      end
    end
    if (load) begin
      mode_nxt      = cmd.mode;
      major_y_nxt   = cmd.major_y;
      minor_dec_nxt = cmd.minor_dec;
      x_nxt         = cmd.x;
      y_nxt         = cmd.y;
      end_nxt       = cmd.walk_end;
      err_nxt       = cmd.err;
      inc_a_nxt     = cmd.inc_a;
      inc_b_nxt     = cmd.inc_b;
      color_nxt     = cmd.color;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_addr_nxt  = out_addr_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = x_r;
      out_y_nxt     = y_r;
      out_addr_nxt  = addr;
      out_color_nxt = color_r;
      out_last_nxt  = at_end;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bre_pkg::MODE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_y_r   <= major_y_nxt;
    minor_dec_r <= minor_dec_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    end_r       <= end_nxt;
    err_r       <= err_nxt;
    inc_a_r     <= inc_a_nxt;
    inc_b_r     <= inc_b_nxt;
    color_r     <= color_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_addr_r  <= out_addr_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign empty         = !out_valid_r;
  assign pixel_x       = out_x_r;
  assign pixel_y       = out_y_r;
  assign pixel_address = out_addr_r;
  assign pixel_color   = out_color_r;
  assign last_pixel    = out_last_r;

endmodule

// File: sv/bresenham_line_rasterizer.sv
// channel   | handshake        | payload
// ----------+------------------+-------------------------------------------------
// line in   | push / full      | in_start_x, in_start_y, in_end_x, in_end_y,
//           |                  | in_line_color
// pixel out | pop / empty      | out_pixel_x, out_pixel_y, out_pixel_address,
//           |                  | out_pixel_color, out_last_pixel
// config    | cfg_we           | cfg_wdata (row width)
//
// a line of N pixels (1 to 64) holds the walker, one pixel per cycle if popped,
// from the single error-step adder; the next queued request loads on the last pixel
// a lone request is queued, loaded by the walker, then its first pixel registered
// reset is synchronous and active low; row width returns to 64, queues empty
// a stalled pop freezes the walker; the request queue keeps taking lines until full

module bresenham_line_rasterizer #(
  parameter int CMD_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  bre_pkg::coord_t               in_start_x,
  input  bre_pkg::coord_t               in_start_y,
  input  bre_pkg::coord_t               in_end_x,
  input  bre_pkg::coord_t               in_end_y,
  input  logic [bre_pkg::COLOR_W-1:0]   in_line_color,
  input  logic                          pop,
  output logic                          empty,
  output bre_pkg::coord_t               out_pixel_x,
  output bre_pkg::coord_t               out_pixel_y,
  output logic [bre_pkg::ADDR_W-1:0]    out_pixel_address,
  output logic [bre_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                          out_last_pixel,
  input  logic                          cfg_we,
  input  logic [bre_pkg::ROW_W-1:0]     cfg_wdata
);

  logic [bre_pkg::ROW_W-1:0] row_width_r, row_width_nxt;
  bre_pkg::cmd_t             front_cmd;
  bre_pkg::cmd_t             head_cmd;
  logic                      head_valid;
  logic                      head_pop;

  assign row_width_nxt = cfg_we ? cfg_wdata : row_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= bre_pkg::ROW_WIDTH_RESET;
    end else begin
      row_width_r <= row_width_nxt;
    end
  end

  bre_front u_front (
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .line_color (in_line_color),
    .cmd        (front_cmd)
  );

  bre_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_cmd  (front_cmd),
    .q_full  (full),
    .rd_en   (head_pop),
    .q_valid (head_valid),
    .rd_cmd  (head_cmd)
  );

  bre_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .row_width     (row_width_r),
    .cmd_valid     (head_valid),
    .cmd           (head_cmd),
    .cmd_pop       (head_pop),
    .pop           (pop),
    .empty         (empty),
    .pixel_x       (out_pixel_x),
    .pixel_y       (out_pixel_y),
    .pixel_address (out_pixel_address),
    .pixel_color   (out_pixel_color),
    .last_pixel    (out_last_pixel)
  );

endmodule
